### rtl/epg_pkg.sv
// shared constants, types and tables for the epicycloid point generator
package epg_pkg;

  localparam int PHASE_BITS   = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int NUM_CELLS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W       = $clog2(TABLE_LEN);
  localparam int CW           = 33;
  localparam int COORD_W      = 16;
  localparam int AMP_W        = 15;
  localparam int STEP_CFG_W   = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int PROD_W       = CW + AMP_W + 1;
  localparam int SUM_W        = PROD_W + 1;
  localparam int FRAC_SHIFT   = 30;
  localparam int RND_W        = SUM_W - FRAC_SHIFT;
  localparam int POS_W        = RND_W + 1;

  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER_STEP = 3'd0,
    REG_INNER_STEP = 3'd1,
    REG_OUTER_AMP  = 3'd2,
    REG_INNER_AMP  = 3'd3,
    REG_CENTER_X   = 3'd4,
    REG_CENTER_Y   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUTER,
    S_INNER,
    S_WAIT,
    S_MUL,
    S_SUM
  } seq_state_t;

  typedef struct packed {
    logic                 vld;
    logic                 tag;
    logic [1:0]           quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cell_data_t;

  function automatic logic signed [CW-1:0] atan_turn(input logic [STEP_W-1:0] idx);
    atan_turn = $signed({1'b0, ATAN_TURNS[idx]});
  endfunction

endpackage

### rtl/epg_in_if.sv
// tick item channel
interface epg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source(output valid, output restart, input ready);
  modport sink(input valid, input restart, output ready);
endinterface

### rtl/epg_out_if.sv
// curve point item channel
interface epg_out_if;
  import epg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      clipped;
  modport source(output valid, output point_x, output point_y, output clipped, input ready);
  modport sink(input valid, input point_x, input point_y, input clipped, output ready);
endinterface

### rtl/epg_cell.sv
// one cordic rotation cell of the chain
module epg_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [epg_pkg::STEP_W-1:0] step_idx,
  input  epg_pkg::cell_data_t        din,
  output epg_pkg::cell_data_t        dout
);
  import epg_pkg::*;

  cell_data_t           data_r;
  cell_data_t           data_nxt;
  logic signed [CW-1:0] x_in;
  logic signed [CW-1:0] y_in;
  logic signed [CW-1:0] z_in;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] ang;

  always_comb begin
    x_in = din.x;
    y_in = din.y;
    z_in = din.z;
    dx   = y_in >>> step_idx;
    dy   = x_in >>> step_idx;
    ang  = atan_turn(step_idx);
    data_nxt      = din;
    if (!z_in[CW-1]) begin
      data_nxt.x = x_in - dx;
      data_nxt.y = y_in + dy;
      data_nxt.z = z_in - ang;
    end else begin
      data_nxt.x = x_in + dx;
      data_nxt.y = y_in - dy;
      data_nxt.z = z_in + ang;
    end
  end

  always_ff @(posedge clk) begin
    data_r.tag  <= data_nxt.tag;
    data_r.quad <= data_nxt.quad;
    data_r.x    <= data_nxt.x;
    data_r.y    <= data_nxt.y;
    data_r.z    <= data_nxt.z;
    if (!rst_n) begin
      data_r.vld <= 1'b0;
    end else begin
      data_r.vld <= data_nxt.vld;
    end
  end

  assign dout = data_r;

endmodule

### rtl/epicycloid_point_generator_top.sv
// epicycloid point generator top level: sequencer, cordic chain and output math
// Each tick item advances the outer and inner phases and yields one curve point
// x = A*cos(outer) - B*cos(inner) + cx, y = A*sin(outer) - B*sin(inner) + cy in Q3.13,
// saturated, with clipped set when either coordinate saturates. Items are handled one
// at a time: the outer angle and then the inner angle enter a row of CORDIC_STEPS
// cordic cells. The next item is taken as soon as the result is in the output
// register, even while it waits.
// Configuration writes take effect at once and should be made only while idle.
module epicycloid_point_generator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [epg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [epg_pkg::CFG_DATA_W-1:0] cfg_data,
  epg_in_if.sink                         in_if,
  epg_out_if.source                      out_if
);
  import epg_pkg::*;

  logic [STEP_CFG_W-1:0]      outer_step_r;
  logic [STEP_CFG_W-1:0]      inner_step_r;
  logic [AMP_W-1:0]           outer_amp_r;
  logic [AMP_W-1:0]           inner_amp_r;
  logic signed [COORD_W-1:0]  center_x_r;
  logic signed [COORD_W-1:0]  center_y_r;

  logic [PHASE_BITS-1:0]      outer_phase_r;
  logic [PHASE_BITS-1:0]      inner_phase_r;
  logic [PHASE_BITS-1:0]      outer_phase_nxt;
  logic [PHASE_BITS-1:0]      inner_phase_nxt;

  seq_state_t                 state_r;
  seq_state_t                 state_nxt;

  logic                       in_take;
  logic                       head_vld;
  logic                       head_tag;
  logic                       mul_en;
  logic                       sum_en;
  logic                       slot_free;

  logic [PHASE_BITS-1:0]      sel_phase;
  logic [31:0]                p32;
  cell_data_t                 head;
  cell_data_t                 chain [NUM_CELLS+1];
  cell_data_t                 tail;
  logic signed [CW-1:0]       c_map;
  logic signed [CW-1:0]       s_map;

  logic signed [CW-1:0]       co_r;
  logic signed [CW-1:0]       so_r;
  logic signed [CW-1:0]       ci_r;
  logic signed [CW-1:0]       si_r;

  logic signed [PROD_W-1:0]   pax_r;
  logic signed [PROD_W-1:0]   pbx_r;
  logic signed [PROD_W-1:0]   pay_r;
  logic signed [PROD_W-1:0]   pby_r;

  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic signed [COORD_W-1:0]  sat_x;
  logic signed [COORD_W-1:0]  sat_y;
  logic                       clip_x;
  logic                       clip_y;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic signed [COORD_W-1:0]  out_x_r;
  logic signed [COORD_W-1:0]  out_y_r;
  logic                       out_clip_r;

  localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(32767);
  localparam logic signed [POS_W-1:0] POS_MIN = -POS_W'(32768);
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << (FRAC_SHIFT - 1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_step_r <= '0;
      inner_step_r <= '0;
      outer_amp_r  <= '0;
      inner_amp_r  <= '0;
      center_x_r   <= '0;
      center_y_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_OUTER_STEP: outer_step_r <= cfg_data[STEP_CFG_W-1:0];
        REG_INNER_STEP: inner_step_r <= cfg_data[STEP_CFG_W-1:0];
        REG_OUTER_AMP:  outer_amp_r  <= cfg_data[AMP_W-1:0];
        REG_INNER_AMP:  inner_amp_r  <= cfg_data[AMP_W-1:0];
        REG_CENTER_X:   center_x_r   <= $signed(cfg_data[COORD_W-1:0]);
        REG_CENTER_Y:   center_y_r   <= $signed(cfg_data[COORD_W-1:0]);
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_if.valid) state_nxt = S_OUTER;
      S_OUTER: state_nxt = S_INNER;
      S_INNER: state_nxt = S_WAIT;
      S_WAIT:  if (tail.vld && tail.tag) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_if.ready = 1'b0;
    head_vld    = 1'b0;
    head_tag    = 1'b0;
    mul_en      = 1'b0;
    sum_en      = 1'b0;
    case (state_r)
      S_IDLE:  in_if.ready = 1'b1;
      S_OUTER: head_vld = 1'b1;
      S_INNER: begin
        head_vld = 1'b1;
        head_tag = 1'b1;
      end
      S_WAIT:  ;
      S_MUL:   mul_en = 1'b1;
      S_SUM:   sum_en = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // phase accumulators
  assign in_take = in_if.valid && in_if.ready;

  always_comb begin
    outer_phase_nxt = outer_phase_r;
    inner_phase_nxt = inner_phase_r;
    if (in_take) begin
      outer_phase_nxt = (in_if.restart ? '0 : outer_phase_r) + PHASE_BITS'(outer_step_r);
      inner_phase_nxt = (in_if.restart ? '0 : inner_phase_r) + PHASE_BITS'(inner_step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_phase_r <= '0;
      inner_phase_r <= '0;
    end else begin
      outer_phase_r <= outer_phase_nxt;
      inner_phase_r <= inner_phase_nxt;
    end
  end

  // chain head
  always_comb begin
    sel_phase = head_tag ? inner_phase_r : outer_phase_r;
    p32       = 32'(sel_phase) << (32 - PHASE_BITS);
    head.vld  = head_vld;
    head.tag  = head_tag;
    head.quad = p32[31:30];
    head.x    = GAIN_Q30;
    head.y    = '0;
    head.z    = $signed({{(CW-30){1'b0}}, p32[29:0]});
  end

  assign chain[0] = head;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    epg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (STEP_W'(g)),
      .din      (chain[g]),
      .dout     (chain[g+1])
    );
  end

  assign tail = chain[NUM_CELLS];

  // quadrant fold
  always_comb begin
    case (tail.quad)
      2'd0: begin
        c_map = tail.x;
        s_map = tail.y;
      end
      2'd1: begin
        c_map = -tail.y;
        s_map = tail.x;
      end
      2'd2: begin
        c_map = -tail.x;
        s_map = -tail.y;
      end
      default: begin
        c_map = tail.y;
        s_map = -tail.x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tail.vld && !tail.tag) begin
      co_r <= c_map;
      so_r <= s_map;
    end
    if (tail.vld && tail.tag) begin
      ci_r <= c_map;
      si_r <= s_map;
    end
  end

  // amplitude products
  always_ff @(posedge clk) begin
    if (mul_en) begin
      pax_r <= PROD_W'($signed({1'b0, outer_amp_r})) * PROD_W'(co_r);
      pbx_r <= PROD_W'($signed({1'b0, inner_amp_r})) * PROD_W'(ci_r);
      pay_r <= PROD_W'($signed({1'b0, outer_amp_r})) * PROD_W'(so_r);
      pby_r <= PROD_W'($signed({1'b0, inner_amp_r})) * PROD_W'(si_r);
    end
  end

  // round, add center, saturate
  always_comb begin
    sum_x = SUM_W'(pax_r) - SUM_W'(pbx_r) + RND_HALF;
    sum_y = SUM_W'(pay_r) - SUM_W'(pby_r) + RND_HALF;
    pos_x = $signed({sum_x[SUM_W-1], sum_x[SUM_W-1:FRAC_SHIFT]}) + POS_W'(center_x_r);
    pos_y = $signed({sum_y[SUM_W-1], sum_y[SUM_W-1:FRAC_SHIFT]}) + POS_W'(center_y_r);
    clip_x = (pos_x > POS_MAX) || (pos_x < POS_MIN);
    clip_y = (pos_y > POS_MAX) || (pos_y < POS_MIN);
    if (pos_x > POS_MAX) begin
      sat_x = COORD_W'(POS_MAX);
    end else if (pos_x < POS_MIN) begin
      sat_x = COORD_W'(POS_MIN);
    end else begin
      sat_x = pos_x[COORD_W-1:0];
    end
    if (pos_y > POS_MAX) begin
      sat_y = COORD_W'(POS_MAX);
    end else if (pos_y < POS_MIN) begin
      sat_y = COORD_W'(POS_MIN);
    end else begin
      sat_y = pos_y[COORD_W-1:0];
    end
  end

  // output register
  assign slot_free = !out_valid_r || out_if.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (sum_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      out_x_r    <= sat_x;
      out_y_r    <= sat_y;
      out_clip_r <= clip_x || clip_y;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.point_x = out_x_r;
  assign out_if.point_y = out_y_r;
  assign out_if.clipped = out_clip_r;

endmodule

### bench/tb_epicycloid_point_generator_top.sv
// testbench for the epicycloid point generator: directed table, then random ticks vs predictor
module tb_epicycloid_point_generator_top;
  import epg_pkg::*;

  localparam int ITEM_LATENCY    = 21;
  localparam int ROTATIONS       = 16;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 63;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;
  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_t;
  typedef enum int {SET_CURVE, SET_NOISE, SET_EXTREME} setting_kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      clip;
  } curve_point_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  restart;
    logic                  known;
    curve_point_t          pt;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  epg_in_if  in_ch();
  epg_out_if out_ch();

  epicycloid_point_generator_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .in_if   (in_ch),
    .out_if  (out_ch)
  );

  logic [PHASE_BITS-1:0]     set_outer_step;
  logic [PHASE_BITS-1:0]     set_inner_step;
  logic [AMP_W-1:0]          set_outer_amp;
  logic [AMP_W-1:0]          set_inner_amp;
  logic signed [COORD_W-1:0] set_center_x;
  logic signed [COORD_W-1:0] set_center_y;
  logic [PHASE_BITS-1:0]     track_outer_phase;
  logic [PHASE_BITS-1:0]     track_inner_phase;

  curve_point_t pending_points[$];
  stim_row_t    directed[$];
  int           mismatches;
  int           tx_idle_pct;
  int           rx_idle_pct;
  bit           hold_req;

  always #5 clk = ~clk;

  function automatic longint arc_turn(input int i);
    case (i)
      0:       arc_turn = 64'h20000000;
      1:       arc_turn = 64'h12E4051E;
      2:       arc_turn = 64'h09FB385B;
      3:       arc_turn = 64'h051111D4;
      4:       arc_turn = 64'h028B0D43;
      5:       arc_turn = 64'h0145D7E1;
      6:       arc_turn = 64'h00A2F61E;
      7:       arc_turn = 64'h00517C55;
      8:       arc_turn = 64'h0028BE53;
      9:       arc_turn = 64'h00145F2F;
      10:      arc_turn = 64'h000A2F98;
      11:      arc_turn = 64'h000517CC;
      12:      arc_turn = 64'h00028BE6;
      13:      arc_turn = 64'h000145F3;
      14:      arc_turn = 64'h0000A2F9;
      default: arc_turn = 64'h0000517C;
    endcase
  endfunction

  function automatic void cordic_cos_sin(input logic [PHASE_BITS-1:0] ph,
                                         output longint c, output longint s);
    logic [31:0] p32;
    longint      x, y, z, dx, dy;
    int          i;
    p32 = 32'(ph) << (32 - PHASE_BITS);
    z   = longint'({2'b00, p32[29:0]});
    x   = CORDIC_GAIN;
    y   = 0;
    for (i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arc_turn(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arc_turn(i);
      end
    end
    case (quadrant_t'(p32[31:30]))
      QUAD_0: begin
        c = x;
        s = y;
      end
      QUAD_1: begin
        c = -y;
        s = x;
      end
      QUAD_2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
  endfunction

  // {saturated, q3.13 value}
  function automatic logic [COORD_W:0] place_q13(input longint a, input longint ta,
                                                 input longint b, input longint tb,
                                                 input longint centre);
    longint v;
    v = ((a * ta - b * tb + (64'sd1 <<< 29)) >>> 30) + centre;
    if (v > 32767) return {1'b1, 16'h7FFF};
    if (v < -32768) return {1'b1, 16'h8000};
    return {1'b0, v[15:0]};
  endfunction

  function automatic curve_point_t next_curve_point(input logic rs);
    longint           co, so, ci, si, a, b;
    logic [COORD_W:0] px, py;
    curve_point_t     pt;
    if (rs) begin
      track_outer_phase = '0;
      track_inner_phase = '0;
    end
    track_outer_phase = track_outer_phase + set_outer_step;
    track_inner_phase = track_inner_phase + set_inner_step;
    cordic_cos_sin(track_outer_phase, co, so);
    cordic_cos_sin(track_inner_phase, ci, si);
    a = longint'(set_outer_amp);
    b = longint'(set_inner_amp);
    px = place_q13(a, co, b, ci, longint'(set_center_x));
    py = place_q13(a, so, b, si, longint'(set_center_y));
    pt.x    = px[COORD_W-1:0];
    pt.y    = py[COORD_W-1:0];
    pt.clip = px[COORD_W] | py[COORD_W];
    return pt;
  endfunction

  function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_OUTER_STEP: set_outer_step = data[PHASE_BITS-1:0];
      REG_INNER_STEP: set_inner_step = data[PHASE_BITS-1:0];
      REG_OUTER_AMP:  set_outer_amp  = data[AMP_W-1:0];
      REG_INNER_AMP:  set_inner_amp  = data[AMP_W-1:0];
      REG_CENTER_X:   set_center_x   = data[COORD_W-1:0];
      REG_CENTER_Y:   set_center_y   = data[COORD_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t tick_row(input logic rs);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_TICK;
    r.restart = rs;
    return r;
  endfunction

  function automatic stim_row_t seen_row(input logic rs, input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y, input logic c);
    stim_row_t r;
    r         = tick_row(rs);
    r.known   = 1'b1;
    r.pt.x    = x;
    r.pt.y    = y;
    r.pt.clip = c;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    store_setting(idx, data);
  endtask

  task automatic send_tick(input logic rs, input logic known, input curve_point_t typed);
    curve_point_t guess;
    int           gap;
    in_ch.valid   <= 1'b1;
    in_ch.restart <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    guess = next_curve_point(rs);
    pending_points.insert(pending_points.size(), known ? typed : guess);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (ITEM_LATENCY + 4) @(posedge clk);
  endtask

  initial begin : result_sink
    int           stall_left;
    int           hold_left;
    bit           hold_done;
    curve_point_t want;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_points.size() == 0) begin
          flag_mismatch($sformatf("point (%0d,%0d) with nothing pending",
                                  out_ch.point_x, out_ch.point_y));
        end else begin
          want = pending_points.pop_front();
          if (out_ch.point_x !== want.x)
            flag_mismatch($sformatf("point_x %0d, expected %0d", out_ch.point_x, want.x));
          if (out_ch.point_y !== want.y)
            flag_mismatch($sformatf("point_y %0d, expected %0d", out_ch.point_y, want.y));
          if (out_ch.clipped !== want.clip)
            flag_mismatch($sformatf("clipped %0b, expected %0b", out_ch.clipped, want.clip));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int            k;
    int            ph;
    int            ratio;
    setting_kind_t how;
    logic [23:0]   ostep, istep, oamp, iamp, cx, cy;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_OUTER_STEP;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    mismatches    = 0;
    tx_idle_pct   = 20;
    rx_idle_pct   = 20;
    hold_req      = 1'b0;
    store_setting(REG_OUTER_STEP, '0);
    store_setting(REG_INNER_STEP, '0);
    store_setting(REG_OUTER_AMP, '0);
    store_setting(REG_INNER_AMP, '0);
    store_setting(REG_CENTER_X, '0);
    store_setting(REG_CENTER_Y, '0);
    track_outer_phase = '0;
    track_inner_phase = '0;

    // reset state, then centre only with masked upper bits
    add_row(seen_row(1'b0, 16'sh0000, 16'sh0000, 1'b0));
    add_row(seen_row(1'b1, 16'sh0000, 16'sh0000, 1'b0));
    add_row(cfg_row(REG_CENTER_X, 24'hFF8000));
    add_row(cfg_row(REG_CENTER_Y, 24'hAA7FFF));
    add_row(cfg_row(REG_OUTER_STEP, 24'hFFFFFF));
    add_row(cfg_row(REG_INNER_STEP, 24'h000001));
    add_row(seen_row(1'b0, 16'sh8000, 16'sh7FFF, 1'b0));
    // unmapped indexes leave everything alone
    add_row(cfg_row(REG_SPARE_6, 24'hFFFFFF));
    add_row(cfg_row(REG_SPARE_7, 24'hFFFFFF));
    add_row(seen_row(1'b1, 16'sh8000, 16'sh7FFF, 1'b0));
    // full outer radius, inner radius masked to zero, saturation
    add_row(cfg_row(REG_OUTER_AMP, 24'hFF7FFF));
    add_row(cfg_row(REG_INNER_AMP, 24'hFF8000));
    add_row(cfg_row(REG_CENTER_X, 24'h007FFF));
    add_row(cfg_row(REG_CENTER_Y, 24'h008000));
    add_row(cfg_row(REG_OUTER_STEP, 24'h000000));
    add_row(cfg_row(REG_INNER_STEP, 24'h800000));
    add_row(tick_row(1'b1));
    add_row(tick_row(1'b0));
    // quarter turns through every quadrant
    add_row(cfg_row(REG_OUTER_STEP, 24'h400000));
    add_row(tick_row(1'b1));
    add_row(tick_row(1'b0));
    add_row(tick_row(1'b0));
    add_row(tick_row(1'b0));
    // both radii at maximum in opposite phase
    add_row(cfg_row(REG_INNER_AMP, 24'h007FFF));
    add_row(cfg_row(REG_CENTER_X, 24'h000000));
    add_row(cfg_row(REG_CENTER_Y, 24'h000000));
    add_row(cfg_row(REG_OUTER_STEP, 24'h000000));
    add_row(tick_row(1'b1));
    add_row(tick_row(1'b0));
    // a proper epicycloid, ratio three
    add_row(cfg_row(REG_OUTER_AMP, 24'h002000));
    add_row(cfg_row(REG_INNER_AMP, 24'h000800));
    add_row(cfg_row(REG_OUTER_STEP, 24'h0AAAAA));
    add_row(cfg_row(REG_INNER_STEP, 24'h2AAAA8));
    add_row(cfg_row(REG_CENTER_X, 24'h001000));
    add_row(cfg_row(REG_CENTER_Y, 24'hFFF000));
    add_row(tick_row(1'b0));
    add_row(tick_row(1'b0));
    add_row(tick_row(1'b0));
    add_row(tick_row(1'b1));
    add_row(tick_row(1'b0));
    add_row(tick_row(1'b0));
    // steps wrap the phase every tick
    add_row(cfg_row(REG_OUTER_STEP, 24'hFFFFFF));
    add_row(cfg_row(REG_INNER_STEP, 24'hFFFFFF));
    add_row(tick_row(1'b0));
    add_row(tick_row(1'b0));
    add_row(tick_row(1'b1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < directed.size(); k++) begin
      if (directed[k].kind == ROW_CFG) begin
        if (k > 0 && directed[k-1].kind == ROW_TICK) wait_idle();
        cfg_write(directed[k].idx, directed[k].data);
      end else begin
        if (k > 0 && directed[k-1].kind == ROW_CFG) cfg_we <= 1'b0;
        send_tick(directed[k].restart, directed[k].known, directed[k].pt);
      end
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      how = setting_kind_t'($urandom_range(0, 2));
      case (how)
        SET_CURVE: begin
          ratio = $urandom_range(1, 7);
          ostep = 24'($urandom_range(1, 24'h080000));
          istep = 24'(ostep * (ratio + 1));
          iamp  = 24'($urandom_range(0, 32767 / (ratio + 1)));
          oamp  = 24'(iamp * (ratio + 1));
          cx    = 24'($urandom_range(0, 16383)) - 24'd8192;
          cy    = 24'($urandom_range(0, 16383)) - 24'd8192;
        end
        SET_NOISE: begin
          ostep = 24'($urandom);
          istep = 24'($urandom);
          oamp  = 24'($urandom);
          iamp  = 24'($urandom);
          cx    = 24'($urandom);
          cy    = 24'($urandom);
        end
        default: begin
          ostep = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
          istep = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h800000;
          oamp  = {9'($urandom), ($urandom_range(0, 1) ? 15'h7FFF : 15'h0000)};
          iamp  = {9'($urandom), ($urandom_range(0, 1) ? 15'h7FFF : 15'h0000)};
          cx    = {8'($urandom), ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)};
          cy    = {8'($urandom), ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)};
        end
      endcase
      cfg_write(REG_OUTER_STEP, ostep);
      cfg_write(REG_INNER_STEP, istep);
      cfg_write(REG_OUTER_AMP, oamp);
      cfg_write(REG_INNER_AMP, iamp);
      cfg_write(REG_CENTER_X, cx);
      cfg_write(REG_CENTER_Y, cy);
      if ($urandom_range(0, 3) == 0)
        cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 24'($urandom));
      cfg_we <= 1'b0;
      if (ph == RANDOM_PHASES - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 10 * $urandom_range(0, 4);
        rx_idle_pct = 10 * $urandom_range(0, 4);
      end
      if (ph == 2) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_tick($urandom_range(0, 19) == 0, 1'b0, '0);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
